// File: hw/rtl/pli_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// pli_pkg
// Shared constants and types for the positional list insert/delete core.
// ----------------------------------------------------------------------------
package pli_pkg;

  localparam int DEFAULT_CAPACITY = 64;

  // Width of the stored words and of the input position field.
  localparam int DATA_W = 32;
  localparam int POS_W  = 8;
  localparam int LEN_W  = 7;

  // Number of match flags examined per cycle by the locate scan.
  localparam int SCAN_GROUP = 8;

  localparam logic [1:0] OP_INSERT = 2'd0;
  localparam logic [1:0] OP_DELETE = 2'd1;
  localparam logic [1:0] OP_LOCATE = 2'd2;

  localparam logic [1:0] STATUS_OK    = 2'd0;
  localparam logic [1:0] STATUS_RANGE = 2'd1;
  localparam logic [1:0] STATUS_FULL  = 2'd2;

  // Command broadcast to every cell of the chain in the cycle an item is accepted.
  typedef struct packed {
    logic              ins;
    logic              del;
    logic              locate;
    logic [POS_W-1:0]  pos0;
    logic [DATA_W-1:0] val;
  } cell_ctl_t;

endpackage
`default_nettype wire

// File: hw/rtl/pli_cell.sv
`default_nettype none
// ----------------------------------------------------------------------------
// pli_cell
// One list entry: shifts towards or away from its neighbours, and compares.
// ----------------------------------------------------------------------------
module pli_cell #(
  parameter int IDX   = 0,
  parameter int IW    = 6,
  parameter int CW    = 7
) (
  input  wire logic                        clk,
  input  wire pli_pkg::cell_ctl_t          ctl,
  input  wire logic [CW-1:0]               count,
  input  wire logic [pli_pkg::DATA_W-1:0]  left_data,
  input  wire logic [pli_pkg::DATA_W-1:0]  right_data,
  output logic      [pli_pkg::DATA_W-1:0]  data,
  output logic      [pli_pkg::DATA_W-1:0]  rd_data,
  output logic                             match
);

  localparam int CMPW = (IW > pli_pkg::POS_W) ? IW : pli_pkg::POS_W;

  logic [pli_pkg::DATA_W-1:0] entry_r, entry_nxt;
  logic                       match_r, match_nxt;
  logic [CMPW-1:0]            idx_c, pos_c;
  logic                       at_pos, past_pos;

  assign idx_c    = CMPW'(IDX);
  assign pos_c    = CMPW'(ctl.pos0);
  assign at_pos   = (idx_c == pos_c);
  assign past_pos = (idx_c > pos_c);

  always_comb begin
    entry_nxt = entry_r;
    if (ctl.ins) begin
      if (past_pos) begin
        entry_nxt = left_data;
      end else if (at_pos) begin
        entry_nxt = ctl.val;
      end
    end else if (ctl.del) begin
      if (past_pos || at_pos) begin
        entry_nxt = right_data;
      end
    end
  end

  assign match_nxt = ctl.locate ? ((entry_r == ctl.val) && (CW'(IDX) < count)) : match_r;

  always_ff @(posedge clk) begin
    entry_r <= entry_nxt;
    match_r <= match_nxt;
  end

  assign data    = entry_r;
  assign rd_data = at_pos ? entry_r : '0;
  assign match   = match_r;

endmodule
`default_nettype wire

// File: hw/rtl/pli_scan.sv
`default_nettype none
// ----------------------------------------------------------------------------
// pli_scan
// Walks the registered match flags a group at a time to find the first hit.
// ----------------------------------------------------------------------------
module pli_scan #(
  parameter int CAPACITY = pli_pkg::DEFAULT_CAPACITY
) (
  input  wire logic                       clk,
  input  wire logic                       rst_n,
  input  wire logic                       clear,
  input  wire logic                       step,
  input  wire logic [CAPACITY-1:0]        match,
  output logic                            hit,
  output logic                            last,
  output logic      [pli_pkg::LEN_W-1:0]  found
);

  localparam int G   = pli_pkg::SCAN_GROUP;
  localparam int NG  = (CAPACITY + G - 1) / G;
  localparam int GW  = (NG > 1) ? $clog2(NG) : 1;
  localparam int SGW = $clog2(G);

  logic [NG*G-1:0] match_pad;
  logic [G-1:0]    grp;
  logic [SGW-1:0]  first;
  logic [GW-1:0]   g_r, g_nxt;

  assign match_pad = (NG*G)'(match);
  assign grp       = match_pad[g_r*G +: G];
  assign hit       = |grp;
  assign last      = (g_r == GW'(NG - 1));

  // Lowest set flag in the current group wins.
  always_comb begin
    first = '0;
    for (int i = G - 1; i >= 0; i--) begin
      if (grp[i]) begin
        first = SGW'(i);
      end
    end
  end

  assign found = pli_pkg::LEN_W'({g_r, first}) + pli_pkg::LEN_W'(1);

  always_comb begin
    g_nxt = g_r;
    if (clear) begin
      g_nxt = '0;
    end else if (step) begin
      g_nxt = g_r + GW'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      g_r <= '0;
    end else begin
      g_r <= g_nxt;
    end
  end

endmodule
`default_nettype wire

// File: hw/rtl/positional_list_insert_delete_core.sv
`default_nettype none
// ----------------------------------------------------------------------------
// positional_list_insert_delete_core
// Ordered list of signed words with positional insert, delete and locate.
// ----------------------------------------------------------------------------
// Insert, delete and unused op codes: the result strobes in the cycle after
// acceptance and a new item may be started in every cycle.
// Locate compares all cells at acceptance, then scans the match flags eight
// per cycle; its result strobes once a group holds a hit or the last group
// is reached, with busy high until then. The receiver cannot stall results.
// Reset (synchronous, rst_n low) empties the list; stored words are not cleared.
// ----------------------------------------------------------------------------
module positional_list_insert_delete_core #(
  parameter int CAPACITY = pli_pkg::DEFAULT_CAPACITY
) (
  input  wire logic                               clk,
  input  wire logic                               rst_n,
  input  wire logic                               start,
  output logic                                    busy,
  input  wire logic        [1:0]                  in_op,
  input  wire logic        [pli_pkg::POS_W-1:0]   in_position,
  input  wire logic signed [pli_pkg::DATA_W-1:0]  in_value,
  output logic                                    out_valid,
  output logic             [1:0]                  out_status,
  output logic signed      [pli_pkg::DATA_W-1:0]  out_removed_value,
  output logic             [pli_pkg::LEN_W-1:0]   out_found_position,
  output logic             [pli_pkg::LEN_W-1:0]   out_list_length
);

  // Index width of a cell and width of the length counter, which must hold
  // CAPACITY itself. Position compares run one bit wider than the wider of the
  // counter and the position field so that count + 1 never wraps.
  localparam int IW = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
  localparam int CW = $clog2(CAPACITY + 1);
  localparam int PW = ((CW > pli_pkg::POS_W) ? CW : pli_pkg::POS_W) + 1;

  // The controller is either free to accept an item, or walking the match
  // flags of a locate.
  typedef enum logic [1:0] {
    ST_IDLE = 2'b01,
    ST_SCAN = 2'b10
  } state_t;

  state_t state_r, state_nxt;

  logic [CW-1:0] count_r, count_nxt;

  logic                       out_valid_r, out_valid_nxt;
  logic [1:0]                 status_r, status_nxt;
  logic [pli_pkg::DATA_W-1:0] removed_r, removed_nxt;
  logic [pli_pkg::LEN_W-1:0]  found_r, found_nxt;

  pli_pkg::cell_ctl_t ctl;

  logic [pli_pkg::DATA_W-1:0] cell_data [CAPACITY];
  logic [pli_pkg::DATA_W-1:0] cell_rd   [CAPACITY];
  logic [CAPACITY-1:0]        cell_match;
  logic [pli_pkg::DATA_W-1:0] rd_sel;

  logic                       accept;
  logic [PW-1:0]              pos_ext, cnt_ext;
  logic                       pos_zero, ins_pos_ok, del_pos_ok, full;

  logic                       scan_clear, scan_step, scan_hit, scan_last;
  logic [pli_pkg::LEN_W-1:0]  scan_found;

  assign accept = start && (state_r == ST_IDLE);
  assign busy   = (state_r != ST_IDLE);

  // Position checks. Insert accepts 1 to count+1, delete 1 to count; a valid
  // insert position on a full list reports full rather than range.
  assign pos_ext    = PW'(in_position);
  assign cnt_ext    = PW'(count_r);
  assign pos_zero   = (in_position == '0);
  assign ins_pos_ok = !pos_zero && (pos_ext <= cnt_ext + PW'(1));
  assign del_pos_ok = !pos_zero && (pos_ext <= cnt_ext);
  assign full       = (count_r == CW'(CAPACITY));

  // The selected cell alone drives its word onto the read lines, so an OR
  // across the row yields the entry at the delete position.
  always_comb begin
    rd_sel = '0;
    for (int k = 0; k < CAPACITY; k++) begin
      rd_sel = rd_sel | cell_rd[k];
    end
  end

  always_comb begin
    ctl            = '0;
    ctl.pos0       = in_position - pli_pkg::POS_W'(1);
    ctl.val        = in_value;
    state_nxt      = state_r;
    count_nxt      = count_r;
    out_valid_nxt  = 1'b0;
    status_nxt     = status_r;
    removed_nxt    = removed_r;
    found_nxt      = found_r;
    scan_clear     = 1'b0;
    scan_step      = 1'b0;

    unique case (state_r)
      ST_IDLE: begin
        if (accept) begin
          status_nxt  = pli_pkg::STATUS_OK;
          removed_nxt = '0;
          found_nxt   = '0;
          unique case (in_op)
            pli_pkg::OP_INSERT: begin
              out_valid_nxt = 1'b1;
              if (!ins_pos_ok) begin
                status_nxt = pli_pkg::STATUS_RANGE;
              end else if (full) begin
                status_nxt = pli_pkg::STATUS_FULL;
              end else begin
                ctl.ins   = 1'b1;
                count_nxt = count_r + CW'(1);
              end
            end
            pli_pkg::OP_DELETE: begin
              out_valid_nxt = 1'b1;
              if (!del_pos_ok) begin
                status_nxt = pli_pkg::STATUS_RANGE;
              end else begin
                ctl.del     = 1'b1;
                removed_nxt = rd_sel;
                count_nxt   = count_r - CW'(1);
              end
            end
            pli_pkg::OP_LOCATE: begin
              // Every cell latches its compare now; the scan starts next cycle.
              ctl.locate = 1'b1;
              scan_clear = 1'b1;
              state_nxt  = ST_SCAN;
            end
            default: begin
              out_valid_nxt = 1'b1;
            end
          endcase
        end
      end
      ST_SCAN: begin
        if (scan_hit || scan_last) begin
          out_valid_nxt = 1'b1;
          found_nxt     = scan_hit ? scan_found : '0;
          state_nxt     = ST_IDLE;
        end else begin
          scan_step = 1'b1;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      count_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      count_r     <= count_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    status_r  <= status_nxt;
    removed_r <= removed_nxt;
    found_r   <= found_nxt;
  end

  // The row of cells. Each cell sees the word of both neighbours; the ends of
  // the row are fed with zero, which only ever lands in unused entries.
  for (genvar k = 0; k < CAPACITY; k++) begin : g_cell
    logic [pli_pkg::DATA_W-1:0] left_w, right_w;

    if (k == 0) begin : g_first
      assign left_w = '0;
    end else begin : g_inner_l
      assign left_w = cell_data[k-1];
    end

    if (k == CAPACITY - 1) begin : g_last
      assign right_w = '0;
    end else begin : g_inner_r
      assign right_w = cell_data[k+1];
    end

    pli_cell #(
      .IDX (k),
      .IW  (IW),
      .CW  (CW)
    ) u_cell (
      .clk        (clk),
      .ctl        (ctl),
      .count      (count_r),
      .left_data  (left_w),
      .right_data (right_w),
      .data       (cell_data[k]),
      .rd_data    (cell_rd[k]),
      .match      (cell_match[k])
    );
  end

  pli_scan #(
    .CAPACITY (CAPACITY)
  ) u_scan (
    .clk   (clk),
    .rst_n (rst_n),
    .clear (scan_clear),
    .step  (scan_step),
    .match (cell_match),
    .hit   (scan_hit),
    .last  (scan_last),
    .found (scan_found)
  );

  // The length reported is the one after the operation, modulo 128.
  assign out_valid          = out_valid_r;
  assign out_status         = status_r;
  assign out_removed_value  = removed_r;
  assign out_found_position = found_r;
  assign out_list_length    = pli_pkg::LEN_W'(count_r);

endmodule
`default_nettype wire
